// ===== rtl/dsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsf_pkg
// shared types and constants of the decimal to single float converter
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam int INT_W      = 4;   // integer digit
    localparam int FRAC_W     = 30;  // fraction digits as an integer
    localparam int LZ_W       = 4;   // leading zeros after the point
    localparam int FLOAT_W    = 32;
    localparam int EXP_W      = 8;
    localparam int MAN_W      = 23;

    // mantissa with hidden bit and round bit, one quotient bit per cell
    localparam int NUM_CELLS  = 25;
    localparam int CNT_W      = 5;

    localparam int MAX_FRACTION_DIGITS = 9;
    localparam logic [EXP_W-1:0] EXP_BIAS_M1 = 8'd126;

    // powers of ten, entries past the last digit are filler and never used
    localparam logic [FRAC_W-1:0] POW10 [0:15] = '{
        30'd1,         30'd10,        30'd100,       30'd1000,
        30'd10000,     30'd100000,    30'd1000000,   30'd10000000,
        30'd100000000, 30'd1000000000,
        30'd1, 30'd1, 30'd1, 30'd1, 30'd1, 30'd1
    };

    // word moved along the row of divider cells
    typedef struct packed {
        logic                 vld;
        logic [FRAC_W-1:0]    rem;
        logic [NUM_CELLS-1:0] quo;
        logic [FRAC_W-1:0]    den;
        logic [INT_W-1:0]     ival;
        logic                 sign;
        logic                 err;
    } t_cell_data;

endpackage

// ===== rtl/dsf_front.sv =====
// ----------------------------------------------------------------------------
// dsf_front
// counts fraction digits, picks the power-of-ten denominator, flags range
// ----------------------------------------------------------------------------
module dsf_front
    import dsf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [INT_W-1:0]  i_ival,
    input  logic [FRAC_W-1:0] i_frac,
    input  logic [LZ_W-1:0]   i_lz,
    input  logic              i_sign,
    output t_cell_data        o_data
);

    t_cell_data r_data;
    logic [3:0] digits;
    logic [4:0] total;
    logic       err;

    // digits = number of powers of ten not above the fraction value
    always_comb begin
        digits = '0;
        for (int k = 0; k <= MAX_FRACTION_DIGITS; k++) begin
            digits = digits + 4'(i_frac >= POW10[k]);
        end
        total = 5'(digits) + 5'(i_lz);
        err   = total > 5'(MAX_FRACTION_DIGITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.vld <= 1'b0;
        end else begin
            r_data.vld <= i_load;
            if (i_load) begin
                r_data.rem  <= i_frac;
                r_data.quo  <= '0;
                r_data.den  <= err ? POW10[0] : POW10[total[3:0]];
                r_data.ival <= i_ival;
                r_data.sign <= i_sign;
                r_data.err  <= err;
            end
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/dsf_cell.sv =====
// ----------------------------------------------------------------------------
// dsf_cell
// one restoring division step: shift, compare, subtract, one quotient bit
// ----------------------------------------------------------------------------
module dsf_cell
    import dsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_data i_data,
    output t_cell_data o_data
);

    t_cell_data        r_data;
    t_cell_data        n_data;
    logic [FRAC_W:0]   shifted;
    logic [FRAC_W:0]   diff;
    logic              ge;

    always_comb begin
        shifted = {i_data.rem, 1'b0};
        diff    = shifted - {1'b0, i_data.den};
        ge      = shifted >= {1'b0, i_data.den};
        n_data  = i_data;
        // remainder stays below the denominator, so it fits back in FRAC_W
        n_data.rem = ge ? diff[FRAC_W-1:0] : shifted[FRAC_W-1:0];
        n_data.quo = {i_data.quo[NUM_CELLS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.vld <= 1'b0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/dsf_norm.sv =====
// ----------------------------------------------------------------------------
// dsf_norm
// joins integer and fraction bits, normalizes, rounds, packs the float
// ----------------------------------------------------------------------------
module dsf_norm
    import dsf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_data         i_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [FLOAT_W-1:0] o_float,
    output logic               o_err,
    output logic               o_done
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_NORM  = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [NUM_CELLS-1:0] r_mant, n_mant;
    logic [EXP_W-1:0]     r_expo, n_expo;
    logic                 r_sign, n_sign;
    logic                 r_err, n_err;
    logic                 r_zero, n_zero;
    logic                 r_out_vld, n_out_vld;
    logic [FLOAT_W-1:0]   r_out_float, n_out_float;
    logic                 r_out_err, n_out_err;

    logic [2:0]           len;
    logic [CNT_W-1:0]     nbits;
    logic [NUM_CELLS:0]   sum;
    logic [NUM_CELLS-1:0] rnd;
    logic [NUM_CELLS-1:0] rnd_fix;
    logic [EXP_W-1:0]     exp_fix;
    logic                 out_free;
    logic                 done;

    always_comb begin
        if (i_data.ival[3])      len = 3'd4;
        else if (i_data.ival[2]) len = 3'd3;
        else if (i_data.ival[1]) len = 3'd2;
        else if (i_data.ival[0]) len = 3'd1;
        else                     len = 3'd0;
        nbits = CNT_W'(NUM_CELLS) - CNT_W'(len);

        // round half up, then undo a carry into the bit above the hidden one
        sum = {1'b0, r_mant} + (NUM_CELLS+1)'(1);
        rnd = sum[NUM_CELLS:1];
        if (rnd[NUM_CELLS-1]) begin
            rnd_fix = rnd >> 1;
            exp_fix = r_expo + 8'd1;
        end else begin
            rnd_fix = rnd;
            exp_fix = r_expo;
        end

        out_free = !r_out_vld || i_out_ready;
        done     = 1'b0;

        n_state     = r_state;
        n_mant      = r_mant;
        n_expo      = r_expo;
        n_sign      = r_sign;
        n_err       = r_err;
        n_zero      = r_zero;
        n_out_vld   = r_out_vld && !i_out_ready;
        n_out_float = r_out_float;
        n_out_err   = r_out_err;

        case (r_state)
            ST_IDLE: begin
                if (i_data.vld) begin
                    n_sign = i_data.sign;
                    n_err  = i_data.err;
                    n_expo = EXP_BIAS_M1 + EXP_W'(len);
                    if (len != 3'd0) begin
                        n_mant = (NUM_CELLS'(i_data.ival) << nbits) | (i_data.quo >> len);
                        n_zero = 1'b0;
                    end else begin
                        n_mant = i_data.quo;
                        n_zero = i_data.quo == '0;
                    end
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                // one left shift per cycle until the leading one sits on top
                if (r_err || r_zero || r_mant[NUM_CELLS-1]) begin
                    n_state = ST_ROUND;
                end else begin
                    n_mant = r_mant << 1;
                    n_expo = r_expo - 8'd1;
                end
            end
            ST_ROUND: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out_err = r_err;
                    if (r_err) begin
                        n_out_float = '0;
                    end else if (r_zero) begin
                        n_out_float = {r_sign, (FLOAT_W-1)'(0)};
                    end else begin
                        n_out_float = {r_sign, exp_fix, rnd_fix[MAN_W-1:0]};
                    end
                    done    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_mant      <= n_mant;
        r_expo      <= n_expo;
        r_sign      <= n_sign;
        r_err       <= n_err;
        r_zero      <= n_zero;
        r_out_float <= n_out_float;
        r_out_err   <= n_out_err;
    end

    assign o_out_valid = r_out_vld;
    assign o_float     = r_out_float;
    assign o_err       = r_out_err;
    assign o_done      = done;

    // a nonzero mantissa always reaches the top bit, so the shift loop ends
    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM && !r_err && !r_zero) |-> (r_mant != '0))
        else $error("normalize loop entered with an empty mantissa");

endmodule

// ===== rtl/decimal_to_single_float.sv =====
// ----------------------------------------------------------------------------
// decimal_to_single_float
// converts a split decimal number into an ieee-754 single bit pattern
// ----------------------------------------------------------------------------
// input word on s_axis: integer digit, fraction digits as an integer, count of
// zeros after the point, and the sign. output word on m_axis: the float bits
// in tdata and a range error flag in tuser (fraction digits plus leading
// zeros above nine; the float bits are then zero).
// one word is converted at a time. the input register feeds a row of 25
// divider cells, each producing one quotient bit of fraction / 10^n, then a
// sequencer normalizes by one bit a cycle, rounds half up and packs.
// an accepted word passes the input register and the row of cells, then the
// sequencer loads it, shifts it until the leading one is on top (no shift
// with a nonzero integer digit), rounds it and hands it to the output register.
// s_axis_tready drops on accept and rises once the result is in the output
// register, so the next word enters while a result still waits on a stalled
// m_axis receiver; that result is held until m_axis_tready.
// reset (synchronous, active low) empties the cell row, the sequencer and
// the output register.
// ----------------------------------------------------------------------------
module decimal_to_single_float
    import dsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] integer_digit, [33:4] fraction_value, [37:34] leading_zeros,
    // [38] negative, [39] zero pad
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] float_bits
    output logic [31:0] m_axis_tdata,
    // [0] range_error
    output logic        m_axis_tuser
);

    logic       r_busy;
    logic       accept;
    logic       done;
    t_cell_data link [0:NUM_CELLS];

    assign accept        = s_axis_tvalid && !r_busy;
    assign s_axis_tready = !r_busy;

    // busy from accept until the result sits in the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    // digit count and denominator select
    dsf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_ival  (s_axis_tdata[3:0]),
        .i_frac  (s_axis_tdata[33:4]),
        .i_lz    (s_axis_tdata[37:34]),
        .i_sign  (s_axis_tdata[38]),
        .o_data  (link[0])
    );

    // row of divider cells, one quotient bit per cell
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        dsf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_data  (link[g]),
            .o_data  (link[g+1])
        );
    end

    // normalize, round, pack and hold the result word
    dsf_norm u_norm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (link[NUM_CELLS]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_float     (m_axis_tdata),
        .o_err       (m_axis_tuser),
        .o_done      (done)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("second word accepted while one is in flight");

    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> r_busy)
        else $error("result produced with no word in flight");

    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0))
        else $error("range error word carries nonzero float bits");

    a_no_denormal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
            (m_axis_tdata[30:23] != 8'd0 || m_axis_tdata[30:0] == 31'd0))
        else $error("nonzero result with a zero exponent");

endmodule

// ===== test/decimal_to_single_float_test.sv =====
// ----------------------------------------------------------------------------
// decimal_to_single_float_test
// self-checking bench for the decimal to single float converter
// ----------------------------------------------------------------------------
// words go in on s_axis as split decimal numbers, and each accepted word is
// run through a bit-exact conversion model kept here. the expected float bits
// and range flag wait in a queue until the converter hands back a word on
// m_axis. a short directed list hits the corner values, then random words
// follow, mostly well-formed numbers with a share of out-of-range and raw
// field noise. both handshakes stall at random
// ----------------------------------------------------------------------------
module decimal_to_single_float_test
    import dsf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS  = 700;
    localparam int DRAIN_LIMIT   = 2000;  // cycles allowed for the last results
    localparam int SETTLE_CYCLES = 60;    // a little above the longest latency

    // expected output of one conversion
    typedef struct packed {
        logic [FLOAT_W-1:0] float_bits;
        logic               range_error;
    } t_float_result;

    // holds the pending conversions and compares what comes out
    class t_conversion_checker;
        t_float_result expected_floats[$];
        int            mismatch_count = 0;

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        // value = ival + frac / 10^(digits of frac + lz), rounded half up
        function t_float_result convert_decimal(logic [INT_W-1:0] ival,
                                                logic [FRAC_W-1:0] frac,
                                                logic [LZ_W-1:0] lz, logic neg);
            t_float_result    res;
            longint unsigned  den;
            longint unsigned  rem;
            int unsigned      ndig;
            int unsigned      blen;
            int unsigned      nfb;
            int               expo;
            logic [31:0]      qbits;
            logic [31:0]      man;
            res = '0;
            den = 1;
            ndig = 0;
            while (den <= frac) begin
                den = den * 10;
                ndig++;
            end
            if (ndig + lz > MAX_FRACTION_DIGITS) begin
                res.range_error = 1'b1;
                return res;
            end
            for (int k = 0; k < lz; k++) den = den * 10;
            blen = 0;
            for (int k = 0; k < INT_W; k++) if (ival[k]) blen = k + 1;
            nfb = NUM_CELLS - blen;
            // long division, one quotient bit per step
            qbits = '0;
            if (frac != 0) begin
                rem = frac;
                for (int k = 0; k < nfb; k++) begin
                    rem = rem << 1;
                    qbits = qbits << 1;
                    if (rem >= den) begin
                        rem = rem - den;
                        qbits[0] = 1'b1;
                    end
                end
            end
            expo = int'(EXP_BIAS_M1) + blen;
            if (blen != 0) begin
                man = (32'(ival) << nfb) | qbits;
            end else begin
                man = qbits;
                if (man == 0) begin
                    res.float_bits = {neg, 31'd0};
                    return res;
                end
                while (!man[24]) begin
                    man = man << 1;
                    expo--;
                end
            end
            man = (man + 1) >> 1;
            if (man[24]) begin
                man = man >> 1;
                expo++;
            end
            res.float_bits = {neg, 8'(expo), man[MAN_W-1:0]};
            return res;
        endfunction

        function void note_word(logic [39:0] w);
            expected_floats.push_back(convert_decimal(w[3:0], w[33:4], w[37:34], w[38]));
        endfunction

        task check_word(logic [FLOAT_W-1:0] got_bits, logic got_err);
            t_float_result want;
            if (expected_floats.size() == 0) begin
                report($sformatf("unexpected result %h err %b", got_bits, got_err));
                return;
            end
            want = expected_floats.pop_front();
            if (got_bits !== want.float_bits)
                report($sformatf("float bits %h, expected %h", got_bits, want.float_bits));
            if (got_err !== want.range_error)
                report($sformatf("range error %b, expected %b", got_err, want.range_error));
        endtask

        task flush_leftovers();
            if (expected_floats.size() != 0)
                report($sformatf("%0d results never arrived", expected_floats.size()));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [3:0] integer_digit, [33:4] fraction_value, [37:34] leading_zeros,
    // [38] negative, [39] zero pad
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] float_bits
    logic [31:0] m_axis_tdata;
    // [0] range_error
    logic        m_axis_tuser;

    t_conversion_checker conversions = new();
    int                  words_sent = 0;

    decimal_to_single_float i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver side: about 8 percent stall cycles, none in a long middle stretch
    always @(negedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else if (words_sent >= 300 && words_sent < 450)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= 8);
    end

    // every word the converter hands back is checked against the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            conversions.check_word(m_axis_tdata, m_axis_tuser);
    end

    // pack the fields, lowest field in the lowest bits
    function automatic logic [39:0] pack_word(logic [INT_W-1:0] ival, logic [FRAC_W-1:0] frac,
                                              logic [LZ_W-1:0] lz, logic neg);
        return {1'b0, neg, lz, frac, ival};
    endfunction

    // present one word, maybe after an idle gap, and hold it until accepted
    task automatic send_word(logic [39:0] w, bit may_idle);
        int gap;
        @(negedge i_clk);
        if (may_idle && $urandom_range(0, 99) < 8) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 60);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        // tready is read before the edge updates it
        do @(posedge i_clk); while (!s_axis_tready);
        conversions.note_word(w);
        words_sent++;
    endtask

    // hold off the sender until every pending result is back
    task automatic wait_for_empty();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (conversions.expected_floats.size() != 0) @(posedge i_clk);
    endtask

    // random word: mostly well-formed numbers, some out of range, some raw noise
    task automatic send_random_word(bit may_idle);
        int unsigned     pick;
        int unsigned     ndig;
        longint unsigned lo;
        logic [INT_W-1:0]  ival;
        logic [FRAC_W-1:0] frac;
        logic [LZ_W-1:0]   lz;
        logic              neg;
        pick = $urandom_range(0, 99);
        neg  = 1'($urandom_range(0, 1));
        ival = ($urandom_range(0, 9) == 0) ? INT_W'($urandom_range(0, 15))
                                           : INT_W'($urandom_range(0, 9));
        // a zero integer digit forces the normalize loop, so make it common
        if ($urandom_range(0, 3) == 0) ival = '0;
        ndig = $urandom_range(0, MAX_FRACTION_DIGITS);
        lo = 1;
        for (int k = 1; k < ndig; k++) lo = lo * 10;
        frac = (ndig == 0) ? '0 : FRAC_W'($urandom_range(32'(lo * 10 - 1), 32'(lo)));
        if (pick < 72) begin
            lz = LZ_W'($urandom_range(0, MAX_FRACTION_DIGITS - ndig));
        end else if (pick < 85) begin
            // one digit too many, or more
            lz = LZ_W'($urandom_range(MAX_FRACTION_DIGITS + 1 - ndig, 15));
        end else begin
            ival = INT_W'($urandom());
            frac = FRAC_W'($urandom());
            lz   = LZ_W'($urandom());
            // also keep raw noise inside the digit limit now and then
            if ($urandom_range(0, 1) == 0) begin
                frac = frac % 30'd1000;
                lz   = lz % 4'd7;
            end
        end
        send_word(pack_word(ival, frac, lz, neg), may_idle);
    endtask

    initial begin
        int drain_cycles;
        // synchronous reset, held low from the start
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner values
        send_word(pack_word(4'd0, 30'd0, 4'd0, 1'b0), 1'b0);          // plus zero
        send_word(pack_word(4'd0, 30'd0, 4'd0, 1'b1), 1'b0);          // minus zero
        send_word(pack_word(4'd0, 30'd0, 4'd9, 1'b0), 1'b0);          // zero, most zeros
        send_word(pack_word(4'd1, 30'd0, 4'd0, 1'b0), 1'b0);          // one
        send_word(pack_word(4'd1, 30'd5, 4'd0, 1'b0), 1'b0);          // 1.5
        send_word(pack_word(4'd0, 30'd1, 4'd0, 1'b0), 1'b0);          // 0.1
        send_word(pack_word(4'd0, 30'd5, 4'd0, 1'b1), 1'b0);          // -0.5
        send_word(pack_word(4'd8, 30'd5, 4'd0, 1'b0), 1'b0);          // 8.5
        send_word(pack_word(4'd0, 30'd1, 4'd8, 1'b0), 1'b0);          // below resolution
        send_word(pack_word(4'd0, 30'd9, 4'd8, 1'b1), 1'b0);          // below resolution
        send_word(pack_word(4'd0, 30'd5, 4'd7, 1'b0), 1'b0);          // deep normalize
        send_word(pack_word(4'd0, 30'd999999999, 4'd0, 1'b0), 1'b0); // rounds up to one
        send_word(pack_word(4'd9, 30'd999999999, 4'd0, 1'b1), 1'b0); // rounds up to ten
        send_word(pack_word(4'd15, 30'd999999999, 4'd0, 1'b1), 1'b0);// digit above nine, carry
        send_word(pack_word(4'd15, 30'd0, 4'd0, 1'b0), 1'b0);         // largest digit
        send_word(pack_word(4'd12, 30'd25, 4'd0, 1'b1), 1'b0);        // -12.25
        send_word(pack_word(4'd2, 30'd12345678, 4'd1, 1'b0), 1'b0);   // exactly nine digits
        send_word(pack_word(4'd0, 30'h3fff_ffff, 4'd0, 1'b0), 1'b0);  // too many digits
        send_word(pack_word(4'd3, 30'd1, 4'd9, 1'b0), 1'b0);          // one digit over
        send_word(pack_word(4'd7, 30'd0, 4'd15, 1'b1), 1'b0);         // largest zero count
        send_word(pack_word(4'd0, 30'd1000000000, 4'd0, 1'b1), 1'b0); // ten digits
        wait_for_empty();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 150 || n == 500) wait_for_empty();
            // no sender idling across a long middle stretch
            send_random_word(!(n >= 300 && n < 450));
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        drain_cycles = 0;
        while (conversions.expected_floats.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        conversions.flush_leftovers();
        if (conversions.mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
